@@ hw/rtl/gdad_pkg.sv @@
package gdad_pkg;

   localparam int unsigned EARLIEST_RESET = 1582;
   localparam int unsigned MONTHS_PER_YEAR = 12;
   localparam int unsigned DAYS_LONG = 31;
   localparam int unsigned DAYS_SHORT = 30;
   localparam int unsigned DAYS_FEB = 28;
   localparam int unsigned QUAD_CENTURY = 400;
   localparam int unsigned CENTURY = 100;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_CHECK,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic check;
      logic walk_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic mod_done;
      logic date_ok;
      logic walk_done;
   } status_type;

   // days in a month; codes outside 1..12 give the short length
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      begin
         len = 5'(DAYS_SHORT);
         if (month == MONTH_FEB) begin
            len = 5'(DAYS_FEB) + {4'd0, leap};
         end else if (month == MONTH_APR || month == MONTH_JUN ||
                      month == MONTH_SEP || month == MONTH_NOV) begin
            len = 5'(DAYS_SHORT);
         end else if (month >= MONTH_JAN && month <= MONTH_DEC) begin
            len = 5'(DAYS_LONG);
         end
         return len;
      end
   endfunction

endpackage

@@ hw/rtl/gdad_ctrl.sv @@
module gdad_ctrl
   import gdad_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (status.mod_done) begin
               state_in = ST_CHECK;
            end else begin
               cmd.mod_step = 1'b1;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = status.date_ok ? ST_WALK : ST_FINISH;
         end
         ST_WALK: begin
            if (status.walk_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

@@ hw/rtl/gdad_datapath.sv @@
module gdad_datapath
   import gdad_pkg::*;
#(
   parameter int YEAR_BITS  = 16,
   parameter int COUNT_BITS = 16
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic [4:0]  start_day,
   input  logic [3:0]  start_month,
   input  logic [15:0] start_year,
   input  logic [15:0] days_to_add,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        date_valid,
   output logic [4:0]  result_day,
   output logic [3:0]  result_month,
   output logic [15:0] result_year,
   output logic        year_overflow
);

   localparam int DAYS_W = COUNT_BITS + 1;
   localparam int DIG_N  = (YEAR_BITS + 7) / 8;
   localparam int PAD_W  = DIG_N * 8;
   localparam int CNT_W  = $clog2(DIG_N + 1);
   localparam int CMP_W  = (YEAR_BITS > 16) ? YEAR_BITS : 16;
   localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};
   // year mod 25: 256 mod 25 is 6, and (v * 41) >> 10 is v / 25 for v below 400
   localparam logic [4:0]  R25_LAST = 5'(CENTURY / 4 - 1);
   localparam logic [14:0] RECIP_25 = 15'd41;

   logic [15:0]          earliest_ff;
   logic [4:0]           day_ff;
   logic [3:0]           month_ff, month_in;
   logic [YEAR_BITS-1:0] year_ff, year_in;
   logic [DAYS_W-1:0]    days_ff, days_in;
   logic [PAD_W-1:0]     shift_ff, shift_in;
   logic [CNT_W-1:0]     bitcnt_ff, bitcnt_in;
   logic [4:0]           r25_ff, r25_in;
   logic                 valid_ff, valid_in;
   logic                 ovf_ff, ovf_in;

   logic                 out_valid_ff;
   logic [4:0]           out_day_ff;
   logic [3:0]           out_month_ff;
   logic [15:0]          out_year_ff;
   logic                 out_ovf_ff;

   logic [7:0]           mod_byte;
   logic [8:0]           mod_sum;
   logic [14:0]          mod_prod;
   logic [4:0]           mod_quo;
   logic [8:0]           mod_q25;
   logic [8:0]           mod_diff;
   logic [4:0]           r25_inc;
   logic                 leap;
   logic [4:0]           mlen;
   logic [DAYS_W-1:0]    mlen_ext;
   logic                 date_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         earliest_ff <= 16'(EARLIEST_RESET);
      end else if (csr_wr_en) begin
         earliest_ff <= csr_wr_data;
      end
   end

   // year mod 25, one year byte per cycle from the top
   assign mod_byte = shift_ff[PAD_W-1 -: 8];
   assign mod_sum  = {2'd0, r25_ff, 2'd0} + {3'd0, r25_ff, 1'b0} + {1'b0, mod_byte};
   assign mod_prod = {6'd0, mod_sum} * RECIP_25;
   assign mod_quo  = mod_prod[14:10];
   assign mod_q25  = {mod_quo, 4'd0} + {1'b0, mod_quo, 3'd0} + {4'd0, mod_quo};
   assign mod_diff = mod_sum - mod_q25;
   assign r25_inc  = (r25_ff == R25_LAST) ? 5'd0 : r25_ff + 5'd1;

   // leap: divisible by 4, and not by 100 unless by 400
   assign leap = (year_ff[1:0] == 2'd0) && ((r25_ff != 5'd0) || (year_ff[3:0] == 4'd0));

   assign mlen     = month_len(month_ff, leap);
   assign mlen_ext = DAYS_W'(mlen);

   assign date_ok = (month_ff >= MONTH_JAN) && (month_ff <= MONTH_DEC) &&
                    (day_ff != 5'd0) && (day_ff <= mlen) &&
                    (CMP_W'(year_ff) >= CMP_W'(earliest_ff));

   assign status.mod_done  = (bitcnt_ff == '0);
   assign status.date_ok   = date_ok;
   assign status.walk_done = ovf_ff || (days_ff <= mlen_ext);

   always_comb begin
      month_in  = month_ff;
      year_in   = year_ff;
      days_in   = days_ff;
      shift_in  = shift_ff;
      bitcnt_in = bitcnt_ff;
      r25_in    = r25_ff;
      valid_in  = valid_ff;
      ovf_in    = ovf_ff;
      if (cmd.load) begin
         month_in  = start_month;
         year_in   = YEAR_BITS'(start_year);
         shift_in  = PAD_W'(YEAR_BITS'(start_year));
         days_in   = DAYS_W'(start_day) + DAYS_W'(COUNT_BITS'(days_to_add));
         bitcnt_in = CNT_W'(DIG_N);
         r25_in    = 5'd0;
         valid_in  = 1'b0;
         ovf_in    = 1'b0;
      end
      if (cmd.mod_step) begin
         r25_in    = mod_diff[4:0];
         shift_in  = {shift_ff[PAD_W-9:0], 8'd0};
         bitcnt_in = bitcnt_ff - CNT_W'(1);
      end
      if (cmd.check) begin
         valid_in = date_ok;
      end
      if (cmd.walk_step) begin
         days_in = days_ff - mlen_ext;
         if (month_ff == MONTH_DEC) begin
            if (year_ff == YEAR_MAX) begin
               ovf_in = 1'b1;
            end else begin
               year_in  = year_ff + YEAR_BITS'(1);
               month_in = MONTH_JAN;
               r25_in   = r25_inc;
            end
         end else begin
            month_in = month_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         day_ff <= start_day;
      end
      month_ff  <= month_in;
      year_ff   <= year_in;
      days_ff   <= days_in;
      shift_ff  <= shift_in;
      bitcnt_ff <= bitcnt_in;
      r25_ff    <= r25_in;
      valid_ff  <= valid_in;
      ovf_ff    <= ovf_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_valid_ff <= valid_ff;
         if (!valid_ff) begin
            out_day_ff   <= 5'd0;
            out_month_ff <= 4'd0;
            out_year_ff  <= 16'd0;
            out_ovf_ff   <= 1'b0;
         end else if (ovf_ff) begin
            out_day_ff   <= 5'(DAYS_LONG);
            out_month_ff <= MONTH_DEC;
            out_year_ff  <= 16'(YEAR_MAX);
            out_ovf_ff   <= 1'b1;
         end else begin
            out_day_ff   <= 5'(days_ff);
            out_month_ff <= month_ff;
            out_year_ff  <= 16'(year_ff);
            out_ovf_ff   <= 1'b0;
         end
      end
   end

   assign date_valid    = out_valid_ff;
   assign result_day    = out_day_ff;
   assign result_month  = out_month_ff;
   assign result_year   = out_year_ff;
   assign year_overflow = out_ovf_ff;

endmodule

@@ hw/rtl/gregorian_date_add_days_unit.sv @@
// gregorian date plus day count
//
// request channel (req_*): one date and a day count per request; the date is
// checked (month 1..12, day within the month, year not below the csr year)
// and the count is added month by month with gregorian month lengths.
// response channel (rsp_*): one response per request; an invalid date gives
// date_valid low and all other fields zero, a year past the top of the
// YEAR_BITS range saturates to 31 december of the largest year with the
// overflow flag set.
// csr port: csr_wr_en writes csr_wr_data into the earliest valid year.
// the year mod 25 is folded in a byte per cycle, then the date is checked;
// a valid date then has one month carried per cycle, at most about 2160
// months for a 16 bit count, while an invalid date skips the walk. one request
// is in work at a time; the next is taken in the cycle after its response is
// loaded.
// the response sits in an output register, so the next request is taken
// while a response still waits; a stalled receiver holds the response and
// stops the unit only when the following result is ready to be written.
// reset clears the control state and sets the earliest year to 1582.
module gregorian_date_add_days_unit
   import gdad_pkg::*;
#(
   parameter int YEAR_BITS  = 16,
   parameter int COUNT_BITS = 16
)(
   input  logic        clock,
   input  logic        reset,
   // request: start_day[4:0], start_month[8:5], start_year[24:9], days_to_add[40:25]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // response: result_day[4:0], result_month[8:5], result_year[24:9]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   // response flags: date_valid[0], year_overflow[1]
   output logic [1:0]  rsp_tuser,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   logic       date_valid;
   logic [4:0] result_day;
   logic [3:0] result_month;
   logic [15:0] result_year;
   logic       year_overflow;

   // sequencer: handshakes and the mod / check / walk steps
   gdad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // date registers, mod 25 folder, month walker and output register
   gdad_datapath #(
      .YEAR_BITS  (YEAR_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .start_day     (req_tdata[4:0]),
      .start_month   (req_tdata[8:5]),
      .start_year    (req_tdata[24:9]),
      .days_to_add   (req_tdata[40:25]),
      .cmd           (cmd),
      .status        (status),
      .date_valid    (date_valid),
      .result_day    (result_day),
      .result_month  (result_month),
      .result_year   (result_year),
      .year_overflow (year_overflow)
   );

   // pack the response, unused high bits zero
   assign rsp_tdata = {7'd0, result_year, result_month, result_day};
   assign rsp_tuser = {year_overflow, date_valid};

endmodule

@@ hw/rtl/gdad_checker.sv @@
module gdad_checker
   import gdad_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // an invalid date gives all zero fields
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 32'd0 && !rsp_tuser[1])
      else $error("invalid date with nonzero fields");

   // a valid result has a month in 1..12 and a nonzero day
   a_valid_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[8:5] >= MONTH_JAN && rsp_tdata[8:5] <= MONTH_DEC &&
         rsp_tdata[4:0] != 5'd0)
      else $error("valid result out of range");

   // overflow saturates to the last day of the year
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |->
         rsp_tuser[0] && rsp_tdata[4:0] == 5'(DAYS_LONG) && rsp_tdata[8:5] == MONTH_DEC)
      else $error("overflow result not saturated");

endmodule

bind gregorian_date_add_days_unit gdad_checker u_gdad_checker (.*);
